[hw/rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/mng_pkg.sv]
// shared codes and types of the mesh normal generator
`timescale 1ns / 1ps
package mng_pkg;

  // command codes carried in s_tuser
  localparam logic [2:0] CMD_LOAD_VERT = 3'd0;
  localparam logic [2:0] CMD_LOAD_NORM = 3'd1;
  localparam logic [2:0] CMD_FACE      = 3'd2;
  localparam logic [2:0] CMD_QUERY     = 3'd3;
  localparam logic [2:0] CMD_CLEAR     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z = 2'd2;

  // result kinds carried in m_tuser
  localparam logic KIND_FACE = 1'b0;
  localparam logic KIND_VERT = 1'b1;

  // one in q2.14
  localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;

  typedef logic signed [63:0] wide_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       take_item;
    logic       load_vert;
    logic       load_norm;
    logic       clear;
    logic       rd_en;
    logic       cap_en;
    logic       set_mean;
    logic       set_sum;
    logic       set_default;
    logic       edge_init;
    logic       shrink_en;
    logic       cross_en;
    logic       norm_start;
    logic       acc_rd;
    logic       acc_wr;
    logic       out_load;
    logic [2:0] cnt;
  } mng_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] vert_ok;
    logic       fnorm_ok;
    logic       shrink_done;
    logic       count_nz;
    logic       norm_done;
    logic       out_free;
  } mng_stat_t;

endpackage

[hw/rtl/mesh_normal_generator.sv]
// Mesh normal generator top level. One command beat is taken at a time on the
// slave stream; loads, clear and unused commands are done in the decode state.
// A face or a query that needs a normalization spends most of its time in the
// normalizer: a one-bit-a-cycle scaling shift of up to 31 steps, squares on one
// multiplier, a 32-step bit-serial square root and a restoring divide for each
// of the three components. A face adds corner reads, edge halving, a cross
// product on one multiplier and sum updates. A query of a bad vertex or of a
// vertex with no faces, and a face with a bad vertex and no valid file normals,
// skip the normalizer; any result can wait for the output register. One result
// can wait in the output register while the next beat is taken. No clearing
// pass: the sum and count entry of a vertex is zeroed when that vertex is loaded.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mesh_normal_generator
  import mng_pkg::*;
#(
  parameter int MAX_VERTICES     = 1024,
  parameter int MAX_FILE_NORMALS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // coord_x, coord_y, coord_z, vert_a, vert_b, vert_c, norm_a, norm_b, norm_c
  input  logic [167:0] s_tdata,
  // cmd
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // normal_x, normal_y, normal_z, bad_index
  output logic [55:0]  m_tdata,
  // kind
  output logic [0:0]   m_tuser
);

  mng_cmd_t  dp_cmd;
  mng_stat_t dp_stat;
  logic      up_vector;

  mng_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  mng_dpath #(
    .MAX_VERTICES     (MAX_VERTICES),
    .MAX_FILE_NORMALS (MAX_FILE_NORMALS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  // output normal equals the up vector
  assign up_vector = (m_tdata[47:0] == 48'h0000_4000_0000);

  // one beat in flight at a time
  `ASSERT_NEXT(a_one_beat, clk, rst, s_tvalid && s_tready, !s_tready)
  // a result is only loaded into a free output register
  `ASSERT_IMPLY(a_load_free, clk, rst, dp_cmd.out_load, !m_tvalid || m_tready)
  // a query of a bad vertex returns the up vector
  `ASSERT_IMPLY(a_bad_query, clk, rst, m_tvalid && (m_tuser[0] == KIND_VERT) && m_tdata[48], up_vector)

endmodule

[hw/rtl/mng_norm.sv]
// iterative vector normalizer: scale, sum of squares, square root, divide
`timescale 1ns / 1ps
module mng_norm
  import mng_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  wide_t               vec [3],
  output logic signed [15:0]  nrm [3],
  output logic                done
);

  typedef enum logic [6:0] {
    N_IDLE  = 7'b0000001,
    N_MAX   = 7'b0000010,
    N_SHIFT = 7'b0000100,
    N_SQ    = 7'b0001000,
    N_ROOT  = 7'b0010000,
    N_DINIT = 7'b0100000,
    N_DSTEP = 7'b1000000
  } nstate_t;

  nstate_t     state;
  logic [62:0] m [3];
  logic        neg [3];
  logic [62:0] mx;
  logic [59:0] prod;
  logic [61:0] rem;
  logic [62:0] root;
  logic [62:0] bitv;
  logic [44:0] rr;
  logic [44:0] dd;
  logic [14:0] q;
  logic [4:0]  step;
  logic [1:0]  comp;

  // root trial value and divide trial bit
  logic [63:0] trial;
  logic        qb;
  logic [14:0] qf;

  assign trial = {1'b0, root} + {1'b0, bitv};
  assign qb    = (rr >= dd);
  assign qf    = {q[13:0], qb};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
      step  <= '0;
      comp  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) begin
            for (int k = 0; k < 3; k++) begin
              m[k]   <= vec[k][63] ? 63'(-vec[k]) : vec[k][62:0];
              neg[k] <= vec[k][63];
            end
            state <= N_MAX;
          end
        end
        N_MAX: begin
          if (m[0] >= m[1] && m[0] >= m[2]) mx <= m[0];
          else if (m[1] >= m[2])            mx <= m[1];
          else                              mx <= m[2];
          state <= N_SHIFT;
        end
        // bring the largest magnitude into [2^29, 2^30); a zero vector gives the up vector
        N_SHIFT: begin
          if (mx == '0) begin
            nrm[0] <= '0;
            nrm[1] <= UNIT_Q14;
            nrm[2] <= '0;
            done   <= 1'b1;
            state  <= N_IDLE;
          end else if (|mx[62:30]) begin
            for (int k = 0; k < 3; k++) m[k] <= m[k] >> 1;
            mx <= mx >> 1;
          end else if (!mx[29]) begin
            for (int k = 0; k < 3; k++) m[k] <= m[k] << 1;
            mx <= mx << 1;
          end else begin
            step  <= '0;
            state <= N_SQ;
          end
        end
        // squares through one multiplier, registered before the add
        N_SQ: begin
          if (step != 5'd3) prod <= m[step[1:0]][29:0] * m[step[1:0]][29:0];
          if (step == 5'd1)      rem <= {2'b00, prod};
          else if (step != 5'd0) rem <= rem + {2'b00, prod};
          if (step == 5'd3) begin
            root  <= '0;
            bitv  <= {1'b1, 62'd0};
            step  <= '0;
            state <= N_ROOT;
          end else begin
            step <= step + 5'd1;
          end
        end
        // one root bit a cycle
        N_ROOT: begin
          if ({2'b00, rem} >= trial) begin
            rem  <= rem - trial[61:0];
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          step <= step + 5'd1;
          if (step == 5'd31) begin
            comp  <= '0;
            state <= N_DINIT;
          end
        end
        // rounded numerator and aligned divisor for one component
        N_DINIT: begin
          rr    <= {1'b0, m[comp][29:0], 14'd0} + 45'(root[30:1]);
          dd    <= {root[30:0], 14'd0};
          q     <= '0;
          step  <= '0;
          state <= N_DSTEP;
        end
        // one quotient bit a cycle
        N_DSTEP: begin
          if (qb) rr <= rr - dd;
          dd   <= dd >> 1;
          q    <= qf;
          step <= step + 5'd1;
          if (step == 5'd14) begin
            nrm[comp] <= neg[comp] ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
            if (comp == 2'd2) begin
              done  <= 1'b1;
              state <= N_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= N_DINIT;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/mng_dpath.sv]
// datapath: mesh stores, edges, cross product, sums and the output register
`timescale 1ns / 1ps
module mng_dpath
  import mng_pkg::*;
#(
  parameter int MAX_VERTICES     = 1024,
  parameter int MAX_FILE_NORMALS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic [167:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tready,
  output logic         m_tvalid,
  output logic [55:0]  m_tdata,
  output logic [0:0]   m_tuser,
  input  mng_cmd_t     cmd,
  output mng_stat_t    stat
);

  localparam int VAW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NAW  = (MAX_FILE_NORMALS > 1) ? $clog2(MAX_FILE_NORMALS) : 1;
  localparam int VTW  = $clog2(MAX_VERTICES + 1);
  localparam int NTW  = $clog2(MAX_FILE_NORMALS + 1);
  localparam int CW_V = (VTW > 10) ? VTW : 10;
  localparam int CW_N = (NTW > 10) ? NTW : 10;
  localparam logic signed [32:0] EDGE_LIM = 33'sd1073741824;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) return v[32] ? 32'sh80000000 : 32'sh7fffffff;
    return v[31:0];
  endfunction

  function automatic logic edge_big(input logic signed [32:0] e);
    return (e >= EDGE_LIM) || (e <= -EDGE_LIM);
  endfunction

  // halve, truncating toward zero
  function automatic logic signed [32:0] half_tz(input logic signed [32:0] e);
    return (e + $signed({32'd0, e[32]})) >>> 1;
  endfunction

  // item registers
  logic [2:0]         cmd_r;
  logic signed [31:0] crd [3];
  logic [10:0]        vi [3];
  logic [10:0]        ni [3];

  logic signed [31:0] off [3];
  logic [VTW-1:0]     vtot;
  logic [NTW-1:0]     ntot;

  logic [95:0]  vmem [MAX_VERTICES];
  logic [95:0]  nmem [MAX_FILE_NORMALS];
  logic [111:0] smem [MAX_VERTICES];
  logic [95:0]  vrd, nrd;
  logic [111:0] srd;

  logic [95:0]        vtx [3];
  logic signed [33:0] mean [3];
  logic signed [32:0] e1 [3];
  logic signed [32:0] e2 [3];
  logic signed [61:0] prod;
  wide_t              vec [3];
  logic signed [15:0] n [3];
  logic signed [15:0] nrm [3];
  logic               norm_done;

  logic [2:0]     vok;
  logic [2:0]     nok;
  logic [1:0]     sel;
  logic [VAW-1:0] vaddr;
  logic [NAW-1:0] naddr;
  logic           vfree, nfree;
  logic           swe;
  logic [VAW-1:0] swaddr;
  logic [111:0]   swdata;
  logic [111:0]   acc_data;
  logic [95:0]    vload;
  logic signed [30:0] opa, opb;
  logic [2:0]     cj;
  logic           out_free;
  logic           bad_o;

  assign sel   = cmd.cnt[1:0];
  assign vaddr = VAW'(vi[sel][9:0]);
  assign naddr = NAW'(ni[sel][9:0]);
  assign vfree = vtot < VTW'(MAX_VERTICES);
  assign nfree = ntot < NTW'(MAX_FILE_NORMALS);

  // index range checks against the loaded totals
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vok[k] = !vi[k][10] && (CW_V'(vi[k][9:0]) < CW_V'(vtot));
      nok[k] = !ni[k][10] && (CW_N'(ni[k][9:0]) < CW_N'(ntot));
    end
  end

  // translated vertex and accumulated sum entry
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vload[32*k +: 32] = sat32($signed({crd[k][31], crd[k]}) + $signed({off[k][31], off[k]}));
      acc_data[32*k +: 32] = sat32($signed({srd[32*k+31], srd[32*k +: 32]}) +
                                   33'(n[k]));
    end
    acc_data[111:96] = (srd[111:96] == 16'hffff) ? srd[111:96] : srd[111:96] + 16'd1;
  end

  // sum store write port: zero on vertex load, update on accumulate
  always_comb begin
    swe    = 1'b0;
    swaddr = VAW'(vtot);
    swdata = '0;
    if (cmd.load_vert && vfree) begin
      swe = 1'b1;
    end else if (cmd.acc_wr) begin
      swe    = 1'b1;
      swaddr = vaddr;
      swdata = acc_data;
    end
  end

  // cross product operand pairs
  always_comb begin
    case (cmd.cnt)
      3'd0:    begin opa = e1[1][30:0]; opb = e2[2][30:0]; end
      3'd1:    begin opa = e1[2][30:0]; opb = e2[1][30:0]; end
      3'd2:    begin opa = e1[2][30:0]; opb = e2[0][30:0]; end
      3'd3:    begin opa = e1[0][30:0]; opb = e2[2][30:0]; end
      3'd4:    begin opa = e1[0][30:0]; opb = e2[1][30:0]; end
      default: begin opa = e1[1][30:0]; opb = e2[0][30:0]; end
    endcase
  end
  assign cj = cmd.cnt - 3'd1;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load_vert && vfree) vmem[VAW'(vtot)] <= vload;
    if (cmd.rd_en) vrd <= vmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_norm && nfree) nmem[NAW'(ntot)] <= {crd[2], crd[1], crd[0]};
    if (cmd.rd_en) nrd <= nmem[naddr];
  end

  always_ff @(posedge clk) begin
    if (swe) smem[swaddr] <= swdata;
    if (cmd.acc_rd) srd <= smem[vaddr];
  end

  // configuration and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      off[0] <= '0;
      off[1] <= '0;
      off[2] <= '0;
      vtot   <= '0;
      ntot   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET_X: off[0] <= cfg_data;
          REG_OFFSET_Y: off[1] <= cfg_data;
          REG_OFFSET_Z: off[2] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) begin
        vtot <= '0;
        ntot <= '0;
      end
      if (cmd.load_vert && vfree) vtot <= vtot + VTW'(1);
      if (cmd.load_norm && nfree) ntot <= ntot + NTW'(1);
    end
  end

  // item capture and face arithmetic
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      cmd_r <= s_tuser;
      for (int k = 0; k < 3; k++) begin
        crd[k] <= s_tdata[32*k +: 32];
        vi[k]  <= s_tdata[96 + 11*k +: 11];
        ni[k]  <= s_tdata[129 + 11*k +: 11];
      end
    end
    if (cmd.cap_en) begin
      vtx[sel] <= vrd;
      for (int k = 0; k < 3; k++) begin
        if (sel == 2'd0) mean[k] <= 34'($signed(nrd[32*k +: 32]));
        else             mean[k] <= mean[k] + 34'($signed(nrd[32*k +: 32]));
      end
    end
    if (cmd.edge_init) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= $signed({vtx[1][32*k+31], vtx[1][32*k +: 32]}) -
                 $signed({vtx[0][32*k+31], vtx[0][32*k +: 32]});
        e2[k] <= $signed({vtx[2][32*k+31], vtx[2][32*k +: 32]}) -
                 $signed({vtx[0][32*k+31], vtx[0][32*k +: 32]});
      end
    end
    if (cmd.shrink_en) begin
      if (edge_big(e1[0]) || edge_big(e1[1]) || edge_big(e1[2])) begin
        for (int k = 0; k < 3; k++) e1[k] <= half_tz(e1[k]);
      end
      if (edge_big(e2[0]) || edge_big(e2[1]) || edge_big(e2[2])) begin
        for (int k = 0; k < 3; k++) e2[k] <= half_tz(e2[k]);
      end
    end
    // one product a cycle, folded into the vector on the next
    if (cmd.cross_en) begin
      if (cmd.cnt != 3'd6) prod <= opa * opb;
      if (cmd.cnt != 3'd0) begin
        if (!cj[0]) vec[cj[2:1]] <= 64'(prod);
        else        vec[cj[2:1]] <= vec[cj[2:1]] - 64'(prod);
      end
    end
    if (cmd.set_mean) begin
      for (int k = 0; k < 3; k++) vec[k] <= 64'(mean[k]);
    end
    if (cmd.set_sum) begin
      for (int k = 0; k < 3; k++) vec[k] <= 64'($signed(srd[32*k +: 32]));
    end
    if (cmd.set_default) begin
      n[0] <= '0;
      n[1] <= UNIT_Q14;
      n[2] <= '0;
    end else if (norm_done) begin
      n <= nrm;
    end
  end

  mng_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.norm_start),
    .vec   (vec),
    .nrm   (nrm),
    .done  (norm_done)
  );

  // output register
  assign out_free = !m_tvalid || m_tready;
  assign bad_o    = (cmd_r == CMD_QUERY) ? !vok[0] : !(&vok);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata    <= {7'd0, bad_o, n[2], n[1], n[0]};
      m_tuser[0] <= (cmd_r == CMD_QUERY) ? KIND_VERT : KIND_FACE;
    end
  end

  // status
  always_comb begin
    stat.cmd         = cmd_r;
    stat.vert_ok     = vok;
    stat.fnorm_ok    = &nok;
    stat.shrink_done = !(edge_big(e1[0]) || edge_big(e1[1]) || edge_big(e1[2]) ||
                         edge_big(e2[0]) || edge_big(e2[1]) || edge_big(e2[2]));
    stat.count_nz    = (srd[111:96] != 16'd0);
    stat.norm_done   = norm_done;
    stat.out_free    = out_free;
  end

endmodule

[hw/rtl/mng_ctrl.sv]
// controller state machine sequencing loads, faces and queries
`timescale 1ns / 1ps
module mng_ctrl
  import mng_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  mng_stat_t stat,
  output mng_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DECODE = 14'b00000000000010,
    S_RD     = 14'b00000000000100,
    S_CAP    = 14'b00000000001000,
    S_DECIDE = 14'b00000000010000,
    S_SHRINK = 14'b00000000100000,
    S_CROSS  = 14'b00000001000000,
    S_NGO    = 14'b00000010000000,
    S_NWAIT  = 14'b00000100000000,
    S_ARD    = 14'b00001000000000,
    S_AWR    = 14'b00010000000000,
    S_QRD    = 14'b00100000000000,
    S_QCAP   = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.cnt    = cnt;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready      = 1'b1;
        cmd.take_item = s_tvalid;
        if (s_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        cnt_next   = '0;
        state_next = S_IDLE;
        case (stat.cmd)
          CMD_LOAD_VERT: cmd.load_vert = 1'b1;
          CMD_LOAD_NORM: cmd.load_norm = 1'b1;
          CMD_CLEAR:     cmd.clear     = 1'b1;
          CMD_FACE:      state_next    = S_RD;
          CMD_QUERY: begin
            if (stat.vert_ok[0]) begin
              state_next = S_QRD;
            end else begin
              cmd.set_default = 1'b1;
              state_next      = S_OUT;
            end
          end
          default: ;
        endcase
      end
      // fetch the three corners
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CAP;
      end
      S_CAP: begin
        cmd.cap_en = 1'b1;
        if (cnt == 3'd2) begin
          state_next = S_DECIDE;
        end else begin
          cnt_next   = cnt + 3'd1;
          state_next = S_RD;
        end
      end
      S_DECIDE: begin
        cnt_next = '0;
        if (stat.fnorm_ok) begin
          cmd.set_mean = 1'b1;
          state_next   = S_NGO;
        end else if (!(&stat.vert_ok)) begin
          cmd.set_default = 1'b1;
          state_next      = S_ARD;
        end else begin
          cmd.edge_init = 1'b1;
          state_next    = S_SHRINK;
        end
      end
      S_SHRINK: begin
        cmd.shrink_en = 1'b1;
        cnt_next      = '0;
        if (stat.shrink_done) state_next = S_CROSS;
      end
      S_CROSS: begin
        cmd.cross_en = 1'b1;
        if (cnt == 3'd6) state_next = S_NGO;
        else             cnt_next   = cnt + 3'd1;
      end
      S_NGO: begin
        cmd.norm_start = 1'b1;
        state_next     = S_NWAIT;
      end
      S_NWAIT: begin
        cnt_next = '0;
        if (stat.norm_done) begin
          state_next = (stat.cmd == CMD_QUERY) ? S_OUT : S_ARD;
        end
      end
      // read-modify-write of the per-vertex sums, one corner at a time
      S_ARD: begin
        if (stat.vert_ok[cnt[1:0]]) begin
          cmd.acc_rd = 1'b1;
          state_next = S_AWR;
        end else if (cnt == 3'd2) begin
          state_next = S_OUT;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      S_AWR: begin
        cmd.acc_wr = 1'b1;
        if (cnt == 3'd2) begin
          state_next = S_OUT;
        end else begin
          cnt_next   = cnt + 3'd1;
          state_next = S_ARD;
        end
      end
      S_QRD: begin
        cmd.acc_rd = 1'b1;
        state_next = S_QCAP;
      end
      S_QCAP: begin
        if (stat.count_nz) begin
          cmd.set_sum = 1'b1;
          state_next  = S_NGO;
        end else begin
          cmd.set_default = 1'b1;
          state_next      = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[dv/mesh_normal_generator_tb.sv]
// self-checking testbench for the mesh normal generator stream block
`timescale 1ns / 1ps
module mesh_normal_generator_tb;
  import mng_pkg::*;

  localparam int VERT_CAP = 1024;
  localparam int NORM_CAP = 1024;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [2:0] cmd;
    logic signed [31:0] cx, cy, cz;
    logic signed [10:0] va, vb, vc, na, nb, nc;
  } mesh_cmd_t;

  typedef struct packed {
    logic kind;
    logic signed [15:0] nx, ny, nz;
    logic bad;
  } normal_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [167:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [0:0] m_tuser;

  mesh_normal_generator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] offs [3];
  logic signed [31:0] vert_mem [VERT_CAP][3];
  logic signed [31:0] fnorm_mem [NORM_CAP][3];
  logic signed [31:0] sum_mem [VERT_CAP][3];
  logic [15:0] count_mem [VERT_CAP];
  int vert_cnt, fnorm_cnt;

  mesh_cmd_t pending_cmds[$];
  normal_res_t expected_normals[$];
  int errors = 0;
  int faces_seen = 0, queries_seen = 0;
  int idle_cycles = 0;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // scale to [2^29, 2^30), then divide by the root of the sum of squares
  function automatic bit unit_vector(input logic signed [63:0] c [3],
                                     output logic signed [15:0] o [3]);
    logic [63:0] m [3];
    logic [63:0] mx, sq, len, q;
    mx = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? -c[i] : c[i];
      if (m[i] > mx) mx = m[i];
    end
    o[0] = 0; o[1] = UNIT_Q14; o[2] = 0;
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    for (int i = 0; i < 3; i++) sq += m[i] * m[i];
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + len / 2) / len;
      o[i] = c[i] < 0 ? -q[15:0] : q[15:0];
    end
    return 1'b1;
  endfunction

  // halve toward zero until every component is below 2^30
  function automatic void halve_edge(inout logic signed [63:0] e [3]);
    logic signed [63:0] mx, a;
    forever begin
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        a = e[i] < 0 ? -e[i] : e[i];
        if (a > mx) mx = a;
      end
      if (mx < (64'sd1 <<< 30)) return;
      for (int i = 0; i < 3; i++) e[i] = e[i] / 2;
    end
  endfunction

  function automatic bit vert_valid(logic signed [10:0] i);
    return i >= 0 && int'(i) < vert_cnt;
  endfunction

  function automatic bit fnorm_valid(logic signed [10:0] i);
    return i >= 0 && int'(i) < fnorm_cnt;
  endfunction

  // update the mesh model for one accepted beat and queue any normal it yields
  task automatic predict_normal(mesh_cmd_t t);
    logic signed [10:0] vi [3], ni [3];
    logic signed [63:0] v [3], e1 [3], e2 [3];
    logic signed [15:0] n [3];
    logic signed [31:0] crd [3];
    bit ok [3];
    bit bad, fok, have;
    normal_res_t r;
    vi = '{t.va, t.vb, t.vc};
    ni = '{t.na, t.nb, t.nc};
    crd = '{t.cx, t.cy, t.cz};
    n = '{16'sd0, UNIT_Q14, 16'sd0};
    v = '{64'sd0, 64'sd0, 64'sd0};
    case (t.cmd)
      CMD_LOAD_VERT: begin
        if (vert_cnt < VERT_CAP) begin
          for (int k = 0; k < 3; k++) begin
            vert_mem[vert_cnt][k] = sat32(64'(crd[k]) + 64'(offs[k]));
            sum_mem[vert_cnt][k] = 0;
          end
          count_mem[vert_cnt] = 0;
          vert_cnt++;
        end
      end
      CMD_LOAD_NORM: begin
        if (fnorm_cnt < NORM_CAP) begin
          for (int k = 0; k < 3; k++) fnorm_mem[fnorm_cnt][k] = crd[k];
          fnorm_cnt++;
        end
      end
      CMD_FACE: begin
        bad = 0;
        fok = 1;
        have = 0;
        for (int i = 0; i < 3; i++) begin
          ok[i] = vert_valid(vi[i]);
          if (!ok[i]) bad = 1;
          if (!fnorm_valid(ni[i])) fok = 0;
        end
        if (fok) begin
          for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) v[k] += 64'(fnorm_mem[ni[i]][k]);
          have = 1;
        end else if (!bad) begin
          for (int k = 0; k < 3; k++) begin
            e1[k] = 64'(vert_mem[vi[1]][k]) - 64'(vert_mem[vi[0]][k]);
            e2[k] = 64'(vert_mem[vi[2]][k]) - 64'(vert_mem[vi[0]][k]);
          end
          halve_edge(e1);
          halve_edge(e2);
          v[0] = e1[1] * e2[2] - e1[2] * e2[1];
          v[1] = e1[2] * e2[0] - e1[0] * e2[2];
          v[2] = e1[0] * e2[1] - e1[1] * e2[0];
          have = 1;
        end
        if (have) void'(unit_vector(v, n));
        for (int i = 0; i < 3; i++) begin
          if (ok[i]) begin
            for (int k = 0; k < 3; k++)
              sum_mem[vi[i]][k] = sat32(64'(sum_mem[vi[i]][k]) + 64'(n[k]));
            if (count_mem[vi[i]] != 16'hffff) count_mem[vi[i]]++;
          end
        end
        r = '{KIND_FACE, n[0], n[1], n[2], bad};
        expected_normals = {expected_normals, r};
      end
      CMD_QUERY: begin
        bad = !vert_valid(vi[0]);
        if (!bad && count_mem[vi[0]] != 0) begin
          for (int k = 0; k < 3; k++) v[k] = 64'(sum_mem[vi[0]][k]);
          void'(unit_vector(v, n));
        end
        r = '{KIND_VERT, n[0], n[1], n[2], bad};
        expected_normals = {expected_normals, r};
      end
      CMD_CLEAR: begin
        for (int i = 0; i < VERT_CAP; i++) begin
          count_mem[i] = 0;
          for (int k = 0; k < 3; k++) sum_mem[i][k] = 0;
        end
        vert_cnt = 0;
        fnorm_cnt = 0;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver: presents queued beats with random gaps
  bit hold_off = 0;
  int send_gap = 0;
  int sent = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_normal(pending_cmds.pop_front());
        sent++;
        send_gap = gap_len();
      end
      if (s_tvalid && !s_tready) begin
        // keep holding the current beat
      end else if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0 && !hold_off) begin
        s_tvalid <= 1'b1;
        s_tdata <= {pending_cmds[0].nc, pending_cmds[0].nb, pending_cmds[0].na,
                    pending_cmds[0].vc, pending_cmds[0].vb, pending_cmds[0].va,
                    pending_cmds[0].cz, pending_cmds[0].cy, pending_cmds[0].cx};
        s_tuser <= pending_cmds[0].cmd;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: random backpressure and field-by-field compare
  int recv_gap = 0;
  normal_res_t want;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_normals.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = expected_normals.pop_front();
          if (m_tuser[0] == KIND_FACE) faces_seen++; else queries_seen++;
          if (m_tuser[0] !== want.kind) report_mismatch("kind", m_tuser[0], want.kind);
          if ($signed(m_tdata[15:0]) !== want.nx)
            report_mismatch("normal_x", $signed(m_tdata[15:0]), want.nx);
          if ($signed(m_tdata[31:16]) !== want.ny)
            report_mismatch("normal_y", $signed(m_tdata[31:16]), want.ny);
          if ($signed(m_tdata[47:32]) !== want.nz)
            report_mismatch("normal_z", $signed(m_tdata[47:32]), want.nz);
          if (m_tdata[48] !== want.bad) report_mismatch("bad_index", m_tdata[48], want.bad);
        end
        recv_gap = gap_len();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || hold_off ||
        (pending_cmds.size() == 0 && expected_normals.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [10:0] rand_index(int total);
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return -11'sd1;
    if (p == 1) return 11'($urandom_range(0, 1023));
    if (total == 0) return 11'sd0;
    return 11'($urandom_range(0, total - 1));
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed(32'($urandom_range(0, 2 * 655360))) - 32'sd655360;
    endcase
  endfunction

  int model_verts, model_norms;

  task automatic add_cmd(logic [2:0] c, logic signed [10:0] a, logic signed [10:0] b,
                         logic signed [10:0] cc, logic signed [10:0] na,
                         logic signed [10:0] nb, logic signed [10:0] nc);
    mesh_cmd_t t;
    t.cmd = c;
    t.cx = rand_coord();
    t.cy = rand_coord();
    t.cz = rand_coord();
    t.va = a; t.vb = b; t.vc = cc;
    t.na = na; t.nb = nb; t.nc = nc;
    if (c == CMD_LOAD_VERT && model_verts < VERT_CAP) model_verts++;
    if (c == CMD_LOAD_NORM && model_norms < NORM_CAP) model_norms++;
    if (c == CMD_CLEAR) begin
      model_verts = 0;
      model_norms = 0;
    end
    pending_cmds = {pending_cmds, t};
  endtask

  // let every queued beat and result go through, then hold the sender
  task automatic drain_and_idle();
    wait (pending_cmds.size() == 0 && !s_tvalid && expected_normals.size() == 0);
    hold_off = 1;
    repeat (300) @(posedge clk);
  endtask

  task automatic write_offset(logic [1:0] idx, logic signed [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    offs[idx] = val;
  endtask

  task automatic random_phase(int count);
    int p;
    logic signed [10:0] a, b, c;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      a = rand_index(model_verts);
      b = rand_index(model_verts);
      c = rand_index(model_verts);
      if (p < 25) add_cmd(CMD_LOAD_VERT, a, b, c, a, b, c);
      else if (p < 35) add_cmd(CMD_LOAD_NORM, a, b, c, a, b, c);
      else if (p < 70)
        add_cmd(CMD_FACE, a, b, c, rand_index(model_norms), rand_index(model_norms),
                rand_index(model_norms));
      else if (p < 95) add_cmd(CMD_QUERY, a, b, c, a, b, c);
      else if (p < 97) add_cmd(CMD_CLEAR, a, b, c, a, b, c);
      else add_cmd(3'($urandom_range(5, 7)), a, b, c, a, b, c);
    end
  endtask

  initial begin
    for (int k = 0; k < 3; k++) offs[k] = 0;
    vert_cnt = 0;
    fnorm_cnt = 0;
    model_verts = 0;
    model_norms = 0;
    for (int i = 0; i < VERT_CAP; i++) begin
      count_mem[i] = 0;
      for (int k = 0; k < 3; k++) sum_mem[i][k] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: queries on empty mesh, loads, normal means, cross faces, bad indexes
    write_offset(REG_OFFSET_X, 32'sh7fffffff);
    write_offset(REG_OFFSET_Y, 32'sh80000000);
    write_offset(REG_OFFSET_Z, 32'sd0);
    hold_off = 0;
    add_cmd(CMD_QUERY, 11'sd0, 11'sd0, 11'sd0, -11'sd1, -11'sd1, -11'sd1);
    add_cmd(CMD_FACE, -11'sd1, 11'sd1023, 11'sd0, -11'sd1, -11'sd1, -11'sd1);
    for (int i = 0; i < 4; i++) add_cmd(CMD_LOAD_VERT, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 3; i++) add_cmd(CMD_LOAD_NORM, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_FACE, 11'sd0, 11'sd1, 11'sd2, 11'sd0, 11'sd1, 11'sd2);
    add_cmd(CMD_FACE, 11'sd0, 11'sd1, 11'sd3, -11'sd1, 11'sd1, 11'sd2);
    add_cmd(CMD_FACE, 11'sd0, 11'sd0, 11'sd0, -11'sd1, -11'sd1, -11'sd1);
    add_cmd(CMD_FACE, 11'sd0, 11'sd1023, 11'sd2, 11'sd0, 11'sd0, 11'sd0);
    add_cmd(CMD_FACE, 11'sd1, -11'sd1, 11'sd2, 11'sd0, 11'sd1, 11'sd1023);
    add_cmd(CMD_QUERY, 11'sd0, 0, 0, 0, 0, 0);
    add_cmd(CMD_QUERY, 11'sd3, 0, 0, 0, 0, 0);
    add_cmd(CMD_QUERY, -11'sd1, 0, 0, 0, 0, 0);
    add_cmd(CMD_QUERY, 11'sd1023, 0, 0, 0, 0, 0);
    add_cmd(3'd5, 0, 0, 0, 0, 0, 0);
    add_cmd(3'd7, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_QUERY, 11'sd0, 0, 0, 0, 0, 0);
    drain_and_idle();

    // random phases under different offsets
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: for (int k = 0; k < 3; k++) write_offset(2'(k), 32'sh80000000);
        1: for (int k = 0; k < 3; k++) write_offset(2'(k), 32'sd0);
        default: for (int k = 0; k < 3; k++) write_offset(2'(k), rand_coord());
      endcase
      hold_off = 0;
      random_phase(ph == 1 ? 50 : 35);
      drain_and_idle();
    end

    // fill the vertex store past its capacity, then a few file normals
    hold_off = 0;
    add_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < VERT_CAP + 2; i++) add_cmd(CMD_LOAD_VERT, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) add_cmd(CMD_LOAD_NORM, 0, 0, 0, 0, 0, 0);
    add_cmd(CMD_FACE, 11'sd1023, 11'sd0, 11'sd512, 11'sd0, 11'sd1, 11'sd7);
    add_cmd(CMD_FACE, 11'sd1023, 11'sd0, 11'sd512, 11'sd1023, 11'sd1, 11'sd7);
    add_cmd(CMD_FACE, 11'sd1023, 11'sd0, 11'sd512, -11'sd1, 11'sd1, 11'sd7);
    add_cmd(CMD_QUERY, 11'sd1023, 0, 0, 0, 0, 0);
    drain_and_idle();

    $display("covered %0d input beats: %0d face and %0d vertex normals checked",
             sent, faces_seen, queries_seen);
    $display("offsets swept through both extremes, vertex store overflow and clear included");
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
